@@ hw/rtl/dlbg_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dlbg_pkg
// Shared widths, types and state codes of the baby-step giant-step solver.
// ----------------------------------------------------------------------------
package dlbg_pkg;

  localparam int unsigned MOD_W     = 31;  // operand and modulus width
  localparam int unsigned EXP_W     = 32;  // exponent width
  localparam int unsigned BKT_AW    = 16;  // bucket memory address width
  localparam int unsigned TAB_AW    = 16;  // entry memory address width
  localparam int unsigned PTR_W     = 17;  // 1 + entry index, 0 means empty
  localparam int unsigned STEP_W    = 16;  // stored baby step
  localparam int unsigned ROOT_W    = 17;  // integer square root
  localparam int unsigned ROOT_BW   = 5;   // root bit index
  localparam int unsigned MUL_CNT_W = 5;   // modular multiplier step count
  localparam int unsigned TABLE_DEPTH = 65536;

  typedef struct packed {
    logic [MOD_W-1:0]  value;
    logic [STEP_W-1:0] step;
    logic [PTR_W-1:0]  link;
  } entry_t;

  typedef enum logic [9:0] {
    ST_IDLE     = 10'b0000000001,
    ST_CLEAR    = 10'b0000000010,
    ST_SQRT     = 10'b0000000100,
    ST_BMUL_V   = 10'b0000001000,
    ST_LK_HEAD  = 10'b0000010000,
    ST_LK_HWAIT = 10'b0000100000,
    ST_LK_ENT   = 10'b0001000000,
    ST_BMUL_P   = 10'b0010000000,
    ST_GMUL     = 10'b0100000000,
    ST_FIN      = 10'b1000000000
  } state_e;

endpackage
`default_nettype wire

@@ hw/rtl/discrete_log_baby_giant.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// discrete_log_baby_giant
// Smallest positive x with base^x = target mod modulus, by baby-step
// giant-step over a hashed table held in two on-chip memories.
// ----------------------------------------------------------------------------
// Usage: a query transaction (base, target, modulus) is taken when in_valid_i
// is high and in_stall_o is low; in_stall_o stays high while a query runs.
// Each query returns one result transaction (found, exponent), held on the
// outputs while out_stall_i is high; a new query may be accepted while a
// finished result still waits to be taken.
// Steps per query: a clearing pass empties the bucket memory, a bit-serial
// search finds the integer square root m of the modulus, then each baby step
// runs two modular multiplications plus a bucket-chain walk, each giant step
// runs one multiplication plus a chain walk, and a final state loads the
// result register, waiting while an earlier result is still held.
// Queries are handled one at a time.
// A zero modulus returns not found after the clearing pass.
// Reset returns the block to idle with no result pending; the memories are
// not touched by reset, since every query empties the bucket memory itself.
// ----------------------------------------------------------------------------
module discrete_log_baby_giant (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       in_valid_i,
  output logic                            in_stall_o,
  input  wire logic [dlbg_pkg::MOD_W-1:0] base_i,
  input  wire logic [dlbg_pkg::MOD_W-1:0] target_i,
  input  wire logic [dlbg_pkg::MOD_W-1:0] modulus_i,
  output logic                            out_valid_o,
  input  wire logic                       out_stall_i,
  output logic                            found_o,
  output logic [dlbg_pkg::EXP_W-1:0]      exponent_o
);

  localparam int unsigned BKT_DEPTH = 2 ** dlbg_pkg::BKT_AW;
  localparam int unsigned ENT_DEPTH = 2 ** dlbg_pkg::TAB_AW;

  dlbg_pkg::state_e state_q, state_d;

  logic [dlbg_pkg::MOD_W-1:0]   a_q, a_d, b_q, b_d, c_q, c_d;
  logic [dlbg_pkg::MOD_W-1:0]   p_q, p_d, acc_q, acc_d, key_q, key_d;
  logic [dlbg_pkg::BKT_AW-1:0]  clr_q, clr_d;
  logic [dlbg_pkg::ROOT_W-1:0]  root_q, root_d;
  logic [dlbg_pkg::ROOT_BW-1:0] rbit_q, rbit_d;
  logic [dlbg_pkg::ROOT_W-1:0]  root_t;
  logic [2*dlbg_pkg::ROOT_W-1:0] root_sq;
  logic [dlbg_pkg::ROOT_W-1:0]  j_q, j_d;
  logic [dlbg_pkg::PTR_W-1:0]   cnt_q, cnt_d, node_q, node_d, head_q, head_d;
  logic [dlbg_pkg::PTR_W-1:0]   head_cur;
  logic [dlbg_pkg::EXP_W-1:0]   gidx_q, gidx_d;
  logic                         giant_q, giant_d;
  logic                         lk_hit, lk_miss;
  logic [dlbg_pkg::STEP_W-1:0]  hit_step;

  logic                         out_valid_q, out_valid_d;
  logic                         found_q, found_d, res_found_q, res_found_d;
  logic [dlbg_pkg::EXP_W-1:0]   exp_q, exp_d, res_exp_q, res_exp_d;

  logic                         mul_start, mul_done;
  logic [dlbg_pkg::MOD_W-1:0]   mul_x, mul_y, mul_res;

  // Bucket heads and table entries.
  logic [dlbg_pkg::PTR_W-1:0]   bkt_mem [BKT_DEPTH];
  logic [dlbg_pkg::PTR_W-1:0]   bkt_rdata_q, bkt_wdata;
  logic [dlbg_pkg::BKT_AW-1:0]  bkt_waddr;
  logic                         bkt_we;
  dlbg_pkg::entry_t             ent_mem [ENT_DEPTH];
  dlbg_pkg::entry_t             ent_rdata_q, ent_wdata;
  logic [dlbg_pkg::TAB_AW-1:0]  ent_raddr, ent_waddr;
  logic                         ent_we;

  dlbg_modmul u_modmul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .x_i     (mul_x),
    .y_i     (mul_y),
    .c_i     (c_q),
    .done_o  (mul_done),
    .result_o(mul_res)
  );

  always_ff @(posedge clk_i) begin
    if (bkt_we) begin
      bkt_mem[bkt_waddr] <= bkt_wdata;
    end
    bkt_rdata_q <= bkt_mem[key_q[dlbg_pkg::BKT_AW-1:0]];
  end

  always_ff @(posedge clk_i) begin
    if (ent_we) begin
      ent_mem[ent_waddr] <= ent_wdata;
    end
    ent_rdata_q <= ent_mem[ent_raddr];
  end

  always_comb begin
    root_t  = root_q | (dlbg_pkg::ROOT_W'(1) << rbit_q);
    root_sq = root_t * root_t;
  end

  assign head_cur = (state_q == dlbg_pkg::ST_LK_HWAIT) ? bkt_rdata_q : head_q;

  always_comb begin
    state_d     = state_q;
    a_d = a_q;  b_d = b_q;  c_d = c_q;
    p_d = p_q;  acc_d = acc_q;  key_d = key_q;
    clr_d = clr_q;  root_d = root_q;  rbit_d = rbit_q;
    j_d = j_q;  cnt_d = cnt_q;  node_d = node_q;  head_d = head_q;
    gidx_d = gidx_q;  giant_d = giant_q;
    res_found_d = res_found_q;  res_exp_d = res_exp_q;
    out_valid_d = out_valid_q;  found_d = found_q;  exp_d = exp_q;
    mul_start = 1'b0;
    mul_x     = p_q;
    mul_y     = a_q;
    bkt_we    = 1'b0;
    bkt_waddr = clr_q;
    bkt_wdata = '0;
    ent_we    = 1'b0;
    ent_waddr = cnt_q[dlbg_pkg::TAB_AW-1:0];
    ent_wdata = '0;
    ent_raddr = dlbg_pkg::TAB_AW'(node_q - 1'b1);
    lk_hit    = 1'b0;
    lk_miss   = 1'b0;
    hit_step  = ent_rdata_q.step;

    if (out_valid_q && !out_stall_i) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      dlbg_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          a_d     = base_i;
          b_d     = target_i;
          c_d     = modulus_i;
          p_d     = (modulus_i == dlbg_pkg::MOD_W'(1)) ? '0 : dlbg_pkg::MOD_W'(1);
          clr_d   = '0;
          state_d = dlbg_pkg::ST_CLEAR;
        end
      end
      dlbg_pkg::ST_CLEAR: begin
        bkt_we = 1'b1;
        clr_d  = clr_q + 1'b1;
        if (&clr_q) begin
          cnt_d       = '0;
          root_d      = '0;
          rbit_d      = dlbg_pkg::ROOT_BW'(dlbg_pkg::ROOT_W - 1);
          res_found_d = 1'b0;
          res_exp_d   = '0;
          state_d     = (c_q == '0) ? dlbg_pkg::ST_FIN : dlbg_pkg::ST_SQRT;
        end
      end
      dlbg_pkg::ST_SQRT: begin
        if (root_sq <= {{(2*dlbg_pkg::ROOT_W-dlbg_pkg::MOD_W){1'b0}}, c_q}) begin
          root_d = root_t;
        end
        rbit_d = rbit_q - 1'b1;
        if (rbit_q == '0) begin
          j_d       = '0;
          giant_d   = 1'b0;
          mul_start = 1'b1;
          mul_x     = p_q;
          mul_y     = b_q;
          state_d   = dlbg_pkg::ST_BMUL_V;
        end
      end
      dlbg_pkg::ST_BMUL_V: begin
        if (mul_done) begin
          key_d   = mul_res;
          state_d = dlbg_pkg::ST_LK_HEAD;
        end
      end
      dlbg_pkg::ST_LK_HEAD: begin
        // The bucket read for key_q completes during this cycle.
        state_d = dlbg_pkg::ST_LK_HWAIT;
      end
      dlbg_pkg::ST_LK_HWAIT: begin
        head_d = bkt_rdata_q;
        node_d = bkt_rdata_q;
        if (bkt_rdata_q == '0) begin
          lk_miss = 1'b1;
        end else begin
          ent_raddr = dlbg_pkg::TAB_AW'(bkt_rdata_q - 1'b1);
          state_d   = dlbg_pkg::ST_LK_ENT;
        end
      end
      dlbg_pkg::ST_LK_ENT: begin
        if (ent_rdata_q.value == key_q) begin
          lk_hit = 1'b1;
        end else if (ent_rdata_q.link == '0) begin
          lk_miss = 1'b1;
        end else begin
          node_d    = ent_rdata_q.link;
          ent_raddr = dlbg_pkg::TAB_AW'(ent_rdata_q.link - 1'b1);
        end
      end
      dlbg_pkg::ST_BMUL_P: begin
        if (mul_done) begin
          p_d = mul_res;
          j_d = j_q + 1'b1;
          if ((j_q + 1'b1) == root_q) begin
            // Giant phase: factor is base^m, the first product uses acc = 1.
            giant_d   = 1'b1;
            acc_d     = dlbg_pkg::MOD_W'(1);
            gidx_d    = dlbg_pkg::EXP_W'(root_q);
            mul_start = 1'b1;
            mul_x     = mul_res;
            mul_y     = dlbg_pkg::MOD_W'(1);
            state_d   = dlbg_pkg::ST_GMUL;
          end else begin
            mul_start = 1'b1;
            mul_x     = mul_res;
            mul_y     = b_q;
            state_d   = dlbg_pkg::ST_BMUL_V;
          end
        end
      end
      dlbg_pkg::ST_GMUL: begin
        if (mul_done) begin
          acc_d   = mul_res;
          key_d   = mul_res;
          state_d = dlbg_pkg::ST_LK_HEAD;
        end
      end
      dlbg_pkg::ST_FIN: begin
        if (!out_valid_q || !out_stall_i) begin
          out_valid_d = 1'b1;
          found_d     = res_found_q;
          exp_d       = res_exp_q;
          state_d     = dlbg_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = dlbg_pkg::ST_IDLE;
      end
    endcase

    if (!giant_q && (lk_hit || lk_miss)) begin
      if (lk_hit) begin
        // A repeated value takes the newer step.
        ent_we    = 1'b1;
        ent_waddr = dlbg_pkg::TAB_AW'(node_q - 1'b1);
        ent_wdata = '{value: ent_rdata_q.value,
                      step:  j_q[dlbg_pkg::STEP_W-1:0],
                      link:  ent_rdata_q.link};
      end else if (cnt_q < dlbg_pkg::PTR_W'(dlbg_pkg::TABLE_DEPTH)) begin
        ent_we    = 1'b1;
        ent_waddr = cnt_q[dlbg_pkg::TAB_AW-1:0];
        ent_wdata = '{value: key_q, step: j_q[dlbg_pkg::STEP_W-1:0], link: head_cur};
        bkt_we    = 1'b1;
        bkt_waddr = key_q[dlbg_pkg::BKT_AW-1:0];
        bkt_wdata = cnt_q + 1'b1;
        cnt_d     = cnt_q + 1'b1;
      end
      mul_start = 1'b1;
      mul_x     = p_q;
      mul_y     = a_q;
      state_d   = dlbg_pkg::ST_BMUL_P;
    end else if (giant_q && lk_hit) begin
      res_found_d = 1'b1;
      res_exp_d   = gidx_q - dlbg_pkg::EXP_W'(hit_step);
      state_d     = dlbg_pkg::ST_FIN;
    end else if (giant_q && lk_miss) begin
      if (gidx_q > dlbg_pkg::EXP_W'(c_q)) begin
        state_d = dlbg_pkg::ST_FIN;
      end else begin
        gidx_d    = gidx_q + dlbg_pkg::EXP_W'(root_q);
        mul_start = 1'b1;
        mul_x     = p_q;
        mul_y     = acc_q;
        state_d   = dlbg_pkg::ST_GMUL;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= dlbg_pkg::ST_IDLE;
      out_valid_q <= 1'b0;
      giant_q     <= 1'b0;
      clr_q       <= '0;
      rbit_q      <= '0;
      cnt_q       <= '0;
      j_q         <= '0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
      giant_q     <= giant_d;
      clr_q       <= clr_d;
      rbit_q      <= rbit_d;
      cnt_q       <= cnt_d;
      j_q         <= j_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a_q         <= a_d;
    b_q         <= b_d;
    c_q         <= c_d;
    p_q         <= p_d;
    acc_q       <= acc_d;
    key_q       <= key_d;
    root_q      <= root_d;
    node_q      <= node_d;
    head_q      <= head_d;
    gidx_q      <= gidx_d;
    res_found_q <= res_found_d;
    res_exp_q   <= res_exp_d;
    found_q     <= found_d;
    exp_q       <= exp_d;
  end

  assign in_stall_o  = (state_q != dlbg_pkg::ST_IDLE);
  assign out_valid_o = out_valid_q;
  assign found_o     = found_q;
  assign exponent_o  = exp_q;

endmodule
`default_nettype wire

@@ hw/rtl/dlbg_modmul.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// dlbg_modmul
// Bit-serial modular multiplier: result = (x * y) mod c, one bit of y per
// cycle, most significant bit first. The operand x must be below c.
// ----------------------------------------------------------------------------
module dlbg_modmul (
  input  wire logic                      clk_i,
  input  wire logic                      rst_ni,
  input  wire logic                      start_i,
  input  wire logic [dlbg_pkg::MOD_W-1:0] x_i,
  input  wire logic [dlbg_pkg::MOD_W-1:0] y_i,
  input  wire logic [dlbg_pkg::MOD_W-1:0] c_i,
  output logic                           done_o,
  output logic [dlbg_pkg::MOD_W-1:0]     result_o
);

  logic                             busy_q, busy_d;
  logic                             done_q, done_d;
  logic [dlbg_pkg::MUL_CNT_W-1:0]   cnt_q, cnt_d;
  logic [dlbg_pkg::MOD_W-1:0]       r_q, r_d;
  logic [dlbg_pkg::MOD_W-1:0]       x_q, x_d;
  logic [dlbg_pkg::MOD_W-1:0]       y_q, y_d;
  logic [dlbg_pkg::MOD_W-1:0]       c_q, c_d;
  logic [dlbg_pkg::MOD_W:0]         dbl;
  logic [dlbg_pkg::MOD_W:0]         sum;
  logic [dlbg_pkg::MOD_W-1:0]       step_r;

  // One step: r = 2r mod c, then r = r + x mod c when the current bit of y is set.
  always_comb begin
    dbl = {r_q, 1'b0};
    if (dbl >= {1'b0, c_q}) begin
      dbl = dbl - {1'b0, c_q};
    end
    sum = {1'b0, dbl[dlbg_pkg::MOD_W-1:0]} +
          (y_q[dlbg_pkg::MOD_W-1] ? {1'b0, x_q} : '0);
    if (sum >= {1'b0, c_q}) begin
      sum = sum - {1'b0, c_q};
    end
    step_r = sum[dlbg_pkg::MOD_W-1:0];
  end

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    r_d    = r_q;
    x_d    = x_q;
    y_d    = y_q;
    c_d    = c_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      r_d    = '0;
      x_d    = x_i;
      y_d    = y_i;
      c_d    = c_i;
    end else if (busy_q) begin
      r_d   = step_r;
      y_d   = {y_q[dlbg_pkg::MOD_W-2:0], 1'b0};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == dlbg_pkg::MUL_CNT_W'(dlbg_pkg::MOD_W - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    r_q <= r_d;
    x_q <= x_d;
    y_q <= y_d;
    c_q <= c_d;
  end

  assign done_o   = done_q;
  assign result_o = r_q;

endmodule
`default_nettype wire
